>>> src/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg: shared constants and helpers for the integer-to-text converter
// Field widths, divider sizing, character codes and the stack control bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int ValueWidth  = 32;
  localparam int RadixWidth  = 6;
  localparam int CharWidth   = 7;
  // quotient bits resolved per cycle by the digit-serial divider
  localparam int DivBits     = 8;
  localparam int DivSteps    = ValueWidth / DivBits;
  localparam int DivCntWidth = $clog2(DivSteps);
  // longest digit run: 32 binary digits
  localparam int StackDepth  = ValueWidth;
  localparam int StackAddrW  = $clog2(StackDepth);
  localparam int StackCntW   = $clog2(StackDepth + 1);

  localparam logic [RadixWidth-1:0] RadixMin   = RadixWidth'(2);
  localparam logic [RadixWidth-1:0] RadixMax   = RadixWidth'(36);
  localparam logic [RadixWidth-1:0] RadixReset = RadixWidth'(10);

  localparam logic [CharWidth-1:0] CharZero  = CharWidth'(8'h30);
  localparam logic [CharWidth-1:0] CharA     = CharWidth'(8'h61);
  localparam logic [CharWidth-1:0] CharMinus = CharWidth'(8'h2d);
  localparam logic [RadixWidth-1:0] DigitMaxNum = RadixWidth'(9);
  localparam logic [RadixWidth-1:0] DigitTen    = RadixWidth'(10);

  // stack control between sequencer and digit store
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  // clamp the raw register into the supported base range
  function automatic logic [RadixWidth-1:0] eff_radix(input logic [RadixWidth-1:0] r);
    logic [RadixWidth-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    else if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

  // map a digit value to its ASCII character
  function automatic logic [CharWidth-1:0] digit_char(input logic [RadixWidth-1:0] d);
    logic [CharWidth-1:0] c;
    if (d > DigitMaxNum) c = CharA + CharWidth'(d - DigitTen);
    else c = CharZero + CharWidth'(d);
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/itoa_div.sv
// ---------------------------------------------------------------------------
// itoa_div: digit-serial divider
// Restoring division of a 32-bit magnitude by the base, eight quotient bits
// per cycle; quotient and remainder are valid when done pulses and hold until the next start.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_div
  import itoa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [ValueWidth-1:0] dividend,
  input  wire logic [RadixWidth-1:0] base,
  output logic                       done,
  output logic [ValueWidth-1:0]      quotient,
  output logic [RadixWidth-1:0]      remainder
);

  logic [ValueWidth-1:0]  q_r, q_nxt;
  logic [RadixWidth-1:0]  rem_r, rem_nxt;
  logic [RadixWidth-1:0]  base_r, base_use;
  logic [DivCntWidth-1:0] cnt_r;
  logic                   run_r;
  logic                   done_r;

  // resolve DivBits quotient bits, shifting dividend out and quotient in
  always_comb begin
    logic [ValueWidth-1:0] q;
    logic [RadixWidth-1:0] rem;
    logic [RadixWidth:0]   t;
    q        = start ? dividend : q_r;
    rem      = start ? '0 : rem_r;
    base_use = start ? base : base_r;
    for (int i = 0; i < DivBits; i++) begin
      t = {rem, q[ValueWidth-1]};
      if (t >= {1'b0, base_use}) begin
        rem = RadixWidth'(t - {1'b0, base_use});
        q   = {q[ValueWidth-2:0], 1'b1};
      end else begin
        rem = t[RadixWidth-1:0];
        q   = {q[ValueWidth-2:0], 1'b0};
      end
    end
    q_nxt   = q;
    rem_nxt = rem;
  end

  // advance the step count and hold the partial results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DivCntWidth'(1);
      end else if (run_r) begin
        cnt_r <= cnt_r + DivCntWidth'(1);
        if (cnt_r == DivCntWidth'(DivSteps - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start || run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
    if (start) base_r <= base;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> src/itoa_dstk.sv
// ---------------------------------------------------------------------------
// itoa_dstk: digit stack
// Holds digits least significant first and hands them back in reverse.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_dstk
  import itoa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire stk_ctl_t              ctl,
  input  wire logic [RadixWidth-1:0] push_digit,
  output logic [RadixWidth-1:0]      top_digit,
  output logic [StackCntW-1:0]       count
);

  logic [RadixWidth-1:0] mem_r [StackDepth];
  logic [StackCntW-1:0]  cnt_r;
  logic [StackCntW-1:0]  top_idx;
  logic [RadixWidth-1:0] top_r;

  // track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      priority if (ctl.push) begin
        cnt_r <= cnt_r + StackCntW'(1);
      end else if (ctl.pop) begin
        cnt_r <= cnt_r - StackCntW'(1);
      end
    end
  end

  // address of the entry that is on top after this cycle's pop
  assign top_idx = cnt_r - (ctl.pop ? StackCntW'(2) : StackCntW'(1));

  // store pushed digit and register the new top entry
  always_ff @(posedge clk) begin
    if (ctl.push) mem_r[cnt_r[StackAddrW-1:0]] <= push_digit;
    if (ctl.push) begin
      top_r <= push_digit;
    end else begin
      top_r <= mem_r[top_idx[StackAddrW-1:0]];
    end
  end

  assign top_digit = top_r;
  assign count     = cnt_r;

endmodule

`default_nettype wire

>>> src/integer_to_ascii_any_base_unit.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_any_base_unit: signed 32-bit value to text in base 2..36
// Emits one ASCII character per output strobe, most significant first.
// ---------------------------------------------------------------------------
// Usage:
//   Input: pulse start with in_value while busy is low; the value is taken
//   at that edge and busy stays high until its last character has gone out.
//   Output: each character appears on out_char_code for one cycle with
//   out_strobe high; out_last_char marks the final one. No NUL follows.
//   The receiver cannot stall, so characters leave at once.
//   Config: cfg_radix is written when cfg_valid and cfg_ready are high;
//   cfg_ready is high whenever the unit is idle. Values below 2 act as 2,
//   above 36 as 36. Reset sets the base to 10.
//   Timing: the divider resolves eight quotient bits per cycle and runs
//   one division per digit. A minus sign leaves in the cycle after the
//   transfer; the digits follow one per cycle once all divisions are done.
//   Reset: synchronous, active low; clears all control state and sets the base to 10.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_any_base_unit
  import itoa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ValueWidth-1:0] in_value,
  output logic                       out_strobe,
  output logic [CharWidth-1:0]       out_char_code,
  output logic                       out_last_char,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [RadixWidth-1:0] cfg_radix
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [RadixWidth-1:0] radix_r;
  logic [RadixWidth-1:0] base_r;
  logic [ValueWidth-1:0] mag;
  logic                  accept;

  logic                  div_start;
  logic [ValueWidth-1:0] div_dividend;
  logic                  div_done;
  logic [ValueWidth-1:0] div_q;
  logic [RadixWidth-1:0] div_rem;

  stk_ctl_t              stk_ctl;
  logic [RadixWidth-1:0] stk_top;
  logic [StackCntW-1:0]  stk_cnt;

  logic                  out_strobe_r;
  logic [CharWidth-1:0]  out_char_r;
  logic                  out_last_r;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign mag       = in_value[ValueWidth-1] ? (ValueWidth'(0) - in_value) : in_value;

  // start a division on transfer and after each digit while quotient remains; push each remainder, pop while emitting
  always_comb begin
    div_start    = 1'b0;
    div_dividend = div_q;
    stk_ctl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        div_start    = accept;
        div_dividend = mag;
      end
      ST_CONV: begin
        stk_ctl.push = div_done;
        div_start    = div_done && (div_q != '0);
      end
      ST_EMIT: begin
        stk_ctl.pop = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // hold base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RadixReset;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_radix;
    end
  end

  // sequence conversion and register the character output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      out_char_r   <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_CONV;
            if (in_value[ValueWidth-1]) begin
              out_strobe_r <= 1'b1;
              out_char_r   <= CharMinus;
            end
          end
        end
        ST_CONV: begin
          if (div_done && (div_q == '0)) state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          out_strobe_r <= 1'b1;
          out_char_r   <= digit_char(stk_top);
          if (stk_cnt == StackCntW'(1)) begin
            out_last_r <= 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // latch the clamped base for this item
  always_ff @(posedge clk) begin
    if (accept) base_r <= eff_radix(radix_r);
  end

  itoa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (state_r == ST_IDLE ? eff_radix(radix_r) : base_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  itoa_dstk u_dstk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (stk_ctl),
    .push_digit (div_rem),
    .top_digit  (stk_top),
    .count      (stk_cnt)
  );

  assign out_strobe    = out_strobe_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  // the final character always coincides with a return to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_char |-> !busy)
    else $error("last character while still busy");

  // a finished division only ever arrives while converting
  a_done_conv: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_CONV)
    else $error("divider result outside conversion");

  // emission never runs on an empty stack
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> stk_cnt != '0)
    else $error("emit with empty digit stack");

  // the stack never overflows
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt <= StackCntW'(StackDepth))
    else $error("digit stack overflow");

endmodule

`default_nettype wire

>>> tb/tb_integer_to_ascii_any_base_unit.sv
// ---------------------------------------------------------------------------
// tb_integer_to_ascii_any_base_unit: self-checking bench for the itoa unit
// Drives signed values through the start/busy port and rewrites the base
// between phases. Every character strobed out is checked against the
// expected text, taken from the table or a local model. A short directed
// table comes first, then random phases with random sender gaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_integer_to_ascii_any_base_unit;
  import itoa_pkg::*;

  typedef struct packed {
    logic [CharWidth-1:0] code;
    logic                 last;
  } text_char_t;

  typedef struct {
    bit                    wr;
    logic [RadixWidth-1:0] radix;
    logic [ValueWidth-1:0] value;
    string                 txt;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic                  busy;
  logic [ValueWidth-1:0] in_value      = '0;
  logic                  out_strobe;
  logic [CharWidth-1:0]  out_char_code;
  logic                  out_last_char;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [RadixWidth-1:0] cfg_radix     = '0;

  // local copy of the base register and the characters still owed
  logic [RadixWidth-1:0] radix_reg = RadixReset;
  text_char_t            exp_chars[$];
  int                    error_count = 0;

  // directed rows: an empty string means the text comes from the model below
  dir_row_t dir_rows [22] = '{
    '{1'b0, 6'd0,  32'd0,          "0"},
    '{1'b0, 6'd0,  32'd123,        "123"},
    '{1'b0, 6'd0,  32'hffffffff,   "-1"},
    '{1'b0, 6'd0,  32'h7fffffff,   "2147483647"},
    '{1'b0, 6'd0,  32'h80000000,   "-2147483648"},
    '{1'b1, 6'd0,  32'h80000000,   ""},
    '{1'b1, 6'd1,  32'd0,          "0"},
    '{1'b1, 6'd2,  32'd5,          "101"},
    '{1'b1, 6'd2,  32'h7fffffff,   ""},
    '{1'b1, 6'd36, 32'd35,         "z"},
    '{1'b1, 6'd36, -32'sd36,       "-10"},
    '{1'b1, 6'd36, 32'h80000000,   ""},
    '{1'b1, 6'd63, 32'd0,          "0"},
    '{1'b1, 6'd63, 32'h7fffffff,   ""},
    '{1'b1, 6'd37, 32'd10,         "a"},
    '{1'b1, 6'd16, 32'hdeadbeef,   ""},
    '{1'b1, 6'd16, 32'd255,        "ff"},
    '{1'b1, 6'd8,  -32'sd8,        "-10"},
    '{1'b1, 6'd3,  32'h55555555,   ""},
    '{1'b1, 6'd10, 32'haaaaaaaa,   ""},
    '{1'b1, 6'd10, 32'h80000001,   "-2147483647"},
    '{1'b1, 6'd35, 32'd34,         "y"}
  };

  integer_to_ascii_any_base_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_radix     (cfg_radix)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // ASCII for one digit value
  function automatic logic [CharWidth-1:0] glyph(input int unsigned d);
    if (d > 9) return CharA + CharWidth'(d - 10);
    return CharZero + CharWidth'(d);
  endfunction

  // queue the text of one value in the current base
  function automatic void predict_text(input logic [ValueWidth-1:0] v);
    int unsigned          base;
    int unsigned          mag;
    int                   nd;
    logic [CharWidth-1:0] dg [32];
    base = radix_reg;
    if (radix_reg < RadixMin) base = RadixMin;
    else if (radix_reg > RadixMax) base = RadixMax;
    mag = v[ValueWidth-1] ? (32'd0 - v) : v;
    nd = 0;
    // collect digits, least significant first
    do begin
      dg[nd] = glyph(mag % base);
      nd++;
      mag = mag / base;
    end while (mag != 0 && nd < 32);
    if (v[ValueWidth-1]) exp_chars.push_back('{CharMinus, 1'b0});
    for (int i = nd - 1; i >= 0; i--) exp_chars.push_back('{dg[i], i == 0});
  endfunction

  // offer one value, hold it until the transfer, then for a nonzero gap drop start and idle for that gap
  task automatic send_value(input logic [ValueWidth-1:0] v, input string txt,
                            input int gap);
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (txt.len() > 0) begin
      for (int i = 0; i < txt.len(); i++)
        exp_chars.push_back('{CharWidth'(txt[i]), i == txt.len() - 1});
    end else begin
      predict_text(v);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and wait until every owed character has come out
  task automatic await_text_drained();
    start <= 1'b0;
    do @(posedge clk); while (exp_chars.size() != 0);
  endtask

  task automatic write_radix(input logic [RadixWidth-1:0] r);
    cfg_valid <= 1'b1;
    cfg_radix <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radix_reg = r;
    cfg_valid <= 1'b0;
  endtask

  // check each strobed character against the oldest one owed
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n && out_strobe) begin
      if (exp_chars.size() == 0) begin
        note_error($sformatf("unexpected char %h last %b", out_char_code, out_last_char));
      end else begin
        want = exp_chars.pop_front();
        if (out_char_code !== want.code)
          note_error($sformatf("char_code exp %h got %h", want.code, out_char_code));
        if (out_last_char !== want.last)
          note_error($sformatf("last_char exp %b got %b", want.last, out_last_char));
      end
    end
  end

  initial begin : stimulus
    int                    sent;
    int                    phase_len;
    bit                    no_idle;
    logic [ValueWidth-1:0] v;
    logic [RadixWidth-1:0] r;
    int                    sh;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        await_text_drained();
        write_radix(dir_rows[i].radix);
      end
      send_value(dir_rows[i].value, dir_rows[i].txt, $urandom_range(0, 4));
    end

    // random phases, each in a freshly written base
    sent = 0;
    while (sent < 450) begin
      await_text_drained();
      case ($urandom_range(0, 19))
        0:       r = RadixWidth'($urandom_range(0, 1));
        1:       r = RadixWidth'($urandom_range(37, 63));
        default: r = RadixWidth'($urandom_range(2, 36));
      endcase
      write_radix(r);
      phase_len = $urandom_range(20, 60);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && sent < 450; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: v = $urandom;
          4, 5: begin
            v = $urandom_range(0, 1000);
            if ($urandom_range(0, 1)) v = -v;
          end
          6: begin
            case ($urandom_range(0, 4))
              0:       v = 32'd0;
              1:       v = 32'hffffffff;
              2:       v = 32'h7fffffff;
              3:       v = 32'h80000000;
              default: v = 32'd1;
            endcase
          end
          7: v = $urandom | 32'h80000000;
          default: begin
            sh = $urandom_range(0, 31);
            v  = $urandom >> sh;
            if ($urandom_range(0, 1)) v = -v;
          end
        endcase
        send_value(v, "", no_idle ? 0 : $urandom_range(0, 4));
        sent++;
        // now and then hold off until the unit has emptied
        if ($urandom_range(0, 39) == 0) await_text_drained();
      end
    end

    await_text_drained();
    repeat (200) @(posedge clk);
    if (exp_chars.size() != 0)
      note_error($sformatf("%0d chars never arrived", exp_chars.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> integer_to_ascii_any_base_unit.f
src/itoa_pkg.sv
src/itoa_div.sv
src/itoa_dstk.sv
src/integer_to_ascii_any_base_unit.sv
tb/tb_integer_to_ascii_any_base_unit.sv
